// File: sv/nearest_task_dispatch_ring_unit_defines.svh
// Assertion macros for the dispatch ring RTL, used by its top level.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef NEAREST_TASK_DISPATCH_RING_UNIT_DEFINES_SVH
`define NEAREST_TASK_DISPATCH_RING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define NTDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define NTDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ntdr_pkg.sv
// Types and constants of the nearest task dispatch ring.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
package ntdr_pkg;

  localparam int SLOT_W = 6;
  localparam int POS_W  = 20;
  localparam int VID_W  = 8;
  localparam int LEN_W  = 20;

  localparam logic [LEN_W-1:0] TRACK_RESET = 20'd80000;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  // Register index as decoded from the configuration address.
  localparam logic CFG_IDX_TRACK = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic              ready_flag;
    logic [VID_W-1:0]  vehicle_id;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] task_slot;
    logic [POS_W-1:0]  distance;
    logic [POS_W-1:0]  target_position;
  } out_item_t;

  // Commands broadcast to every task cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic take;
  } cell_cmd_t;

  // Tags of one element in the reduction stream.
  typedef struct packed {
    logic valid;
    logic vehicle;
    logic ready;
    logic last;
  } elem_ctl_t;

  typedef struct packed {
    logic done;
    logic found;
  } pick_sts_t;

endpackage

// File: sv/ntdr_cell.sv
// One task cell of the ring: ready flag, pickup position and owner of a slot.
// Uses ntdr_pkg for the command struct.
module ntdr_cell #(
  parameter int PW  = 20,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ntdr_pkg::cell_cmd_t        cmd,
  input  logic [IW-1:0]              addr,
  input  logic                       ld_ready,
  input  logic [PW-1:0]              ld_pos,
  input  logic [ntdr_pkg::VID_W-1:0] owner_i,
  input  logic                       nb_ready,
  input  logic [PW-1:0]              nb_pos,
  output logic                       ready_o,
  output logic [PW-1:0]              pos_o
);

  logic                       ready_r, ready_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [ntdr_pkg::VID_W-1:0] owner_r, owner_nxt;
  logic                       hit;

  assign hit = (addr == IW'(IDX));

  always_comb begin
    ready_nxt = ready_r;
    pos_nxt   = pos_r;
    owner_nxt = owner_r;
    if (cmd.shift) begin
      ready_nxt = nb_ready;
      pos_nxt   = nb_pos;
    end else if (cmd.load && hit) begin
      ready_nxt = ld_ready;
      pos_nxt   = ld_pos;
    end else if (cmd.take && hit) begin
      ready_nxt = 1'b0;
      owner_nxt = owner_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    owner_r <= owner_nxt;
  end

  assign ready_o = ready_r;
  assign pos_o   = pos_r;

endmodule

// File: sv/ntdr_rdc_stage.sv
// One restoring step of the ring-position reduction pipeline.
// Uses ntdr_pkg for the element tag struct and the track length width.
module ntdr_rdc_stage #(
  parameter int PW    = 20,
  parameter int IW    = 6,
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ntdr_pkg::LEN_W-1:0] trk_len,
  input  ntdr_pkg::elem_ctl_t        ctl_i,
  input  logic [PW-1:0]              rem_i,
  input  logic [PW-1:0]              raw_i,
  input  logic [IW-1:0]              idx_i,
  output ntdr_pkg::elem_ctl_t        ctl_o,
  output logic [PW-1:0]              rem_o,
  output logic [PW-1:0]              raw_o,
  output logic [IW-1:0]              idx_o
);

  localparam int WW = PW + ntdr_pkg::LEN_W;

  ntdr_pkg::elem_ctl_t ctl_r;
  logic [PW-1:0]       rem_r, rem_nxt, raw_r;
  logic [IW-1:0]       idx_r;
  logic [WW-1:0]       dv;
  logic [WW-1:0]       rem_w;

  // The remainder entering this step is below twice the shifted length,
  // so one compare and subtract settles this bit of the quotient.
  assign dv    = WW'(trk_len) << SHIFT;
  assign rem_w = WW'(rem_i);

  always_comb begin
    rem_nxt = rem_i;
    if (trk_len != '0 && rem_w >= dv) begin
      rem_nxt = rem_i - dv[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    raw_r <= raw_i;
    idx_r <= idx_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign raw_o = raw_r;
  assign idx_o = idx_r;

endmodule

// File: sv/ntdr_pick.sv
// Forward ring distance and running minimum over the reduced slot stream.
// Uses ntdr_pkg for the element tag and status structs.
module ntdr_pick #(
  parameter int PW = 20,
  parameter int IW = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic [ntdr_pkg::LEN_W-1:0] trk_len,
  input  ntdr_pkg::elem_ctl_t        ctl_i,
  input  logic [PW-1:0]              rem_i,
  input  logic [PW-1:0]              raw_i,
  input  logic [IW-1:0]              idx_i,
  output ntdr_pkg::pick_sts_t        sts_o,
  output logic [IW-1:0]              best_idx_o,
  output logic [ntdr_pkg::LEN_W-1:0] best_dist_o,
  output logic [PW-1:0]              best_raw_o
);

  localparam int LW = ntdr_pkg::LEN_W;

  logic [PW-1:0]       a_r;
  logic [31:0]         a32, b32;
  logic [LW-1:0]       a_l, b_l, dist_nxt;
  ntdr_pkg::elem_ctl_t d_ctl_r;
  logic [LW-1:0]       d_dist_r;
  logic [IW-1:0]       d_idx_r;
  logic [PW-1:0]       d_raw_r;
  logic                have_r, done_r, better;
  logic [LW-1:0]       best_dist_r;
  logic [IW-1:0]       best_idx_r;
  logic [PW-1:0]       best_raw_r;

  assign a32 = 32'(a_r);
  assign b32 = 32'(rem_i);
  assign a_l = a32[LW-1:0];
  assign b_l = b32[LW-1:0];

  // Both operands are already below the track length, so neither form
  // of the forward distance can overflow.
  always_comb begin
    if (trk_len == '0) begin
      dist_nxt = '0;
    end else if (b_l >= a_l) begin
      dist_nxt = b_l - a_l;
    end else begin
      dist_nxt = (trk_len - a_l) + b_l;
    end
  end

  assign better = d_ctl_r.valid && !d_ctl_r.vehicle && d_ctl_r.ready &&
                  (!have_r || d_dist_r < best_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_ctl_r <= '0;
      have_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      d_ctl_r <= ctl_i;
      done_r  <= d_ctl_r.valid && d_ctl_r.last;
      if (clr) begin
        have_r <= 1'b0;
      end else if (better) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.valid && ctl_i.vehicle) begin
      a_r <= rem_i;
    end
    d_dist_r <= dist_nxt;
    d_idx_r  <= idx_i;
    d_raw_r  <= raw_i;
    if (better) begin
      best_dist_r <= d_dist_r;
      best_idx_r  <= d_idx_r;
      best_raw_r  <= d_raw_r;
    end
  end

  assign sts_o.done  = done_r;
  assign sts_o.found = have_r;
  assign best_idx_o  = best_idx_r;
  assign best_dist_o = best_dist_r;
  assign best_raw_o  = best_raw_r;

endmodule

// File: sv/nearest_task_dispatch_ring_unit.sv
// Top level of the nearest task dispatch ring: command port, task cell ring,
// reduction pipeline and picker. Uses ntdr_pkg, ntdr_cell, ntdr_rdc_stage,
// ntdr_pick and the assertion macros header.
`include "nearest_task_dispatch_ring_unit_defines.svh"

// A load item, or a dispatch from a vehicle that is not idle, gives its
// result in the cycle after it is accepted. A dispatch from an idle vehicle
// rotates all TASK_SLOTS entries of the cell ring past the head cell once,
// one slot per cycle, behind the vehicle position, and every element passes
// a restoring reduction pipeline of PW = min(POS_BITS, 20) steps, then the
// distance stage and the running minimum; its result is registered after the
// picker reports that the last slot has passed. busy is low again in the
// cycle the result is shown, so the next item can be taken then. Each result
// is shown for exactly one cycle with out_valid high; the receiver must take it,
// as the block cannot be held off. Track length must be written only while
// busy is low; the block itself does not enforce this.
module nearest_task_dispatch_ring_unit #(
  parameter int TASK_SLOTS = 64,
  parameter int POS_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ntdr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ntdr_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int PW = (POS_BITS < ntdr_pkg::POS_W) ? POS_BITS : ntdr_pkg::POS_W;
  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 2);
  localparam int LW = ntdr_pkg::LEN_W;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ntdr_pkg::out_item_t        out_item_r, out_item_nxt;
  logic [CW-1:0]              feed_cnt_r, feed_cnt_nxt;
  logic [PW-1:0]              veh_pos_r, veh_pos_nxt;
  logic [ntdr_pkg::VID_W-1:0] veh_id_r, veh_id_nxt;
  logic [LW-1:0]              trk_len_r;

  logic                       accept;
  logic                       cfg_wr;
  logic                       slot_hit;
  logic [31:0]                slot32;
  logic [IW-1:0]              ld_addr;
  logic                       feed_on;
  logic                       feed_veh;
  logic [CW-1:0]              cnt_m1;
  ntdr_pkg::cell_cmd_t        cmd;
  logic [IW-1:0]              cell_addr;

  logic                       c_ready [TASK_SLOTS];
  logic [PW-1:0]              c_pos   [TASK_SLOTS];

  ntdr_pkg::elem_ctl_t        p_ctl [PW+1];
  logic [PW-1:0]              p_rem [PW+1];
  logic [PW-1:0]              p_raw [PW+1];
  logic [IW-1:0]              p_idx [PW+1];

  ntdr_pkg::pick_sts_t        sts;
  logic [IW-1:0]              best_idx;
  logic [LW-1:0]              best_dist;
  logic [PW-1:0]              best_raw;
  logic [31:0]                best_idx32, best_raw32;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == ntdr_pkg::CFG_IDX_TRACK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_len_r <= ntdr_pkg::TRACK_RESET;
    end else if (cfg_wr) begin
      trk_len_r <= cfg_pwdata[LW-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      ntdr_pkg::CFG_IDX_TRACK: cfg_prdata = 32'(trk_len_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Load addressing; a slot beyond the table leaves every cell alone.
  assign slot32   = 32'(in_item.slot);
  assign slot_hit = (slot32 < TASK_SLOTS);
  assign ld_addr  = slot32[IW-1:0];

  // Feeder: the vehicle position first, then one slot per cycle from the
  // head cell while the ring rotates by one.
  assign feed_on  = (state_r == ST_SCAN) && (32'(feed_cnt_r) <= TASK_SLOTS);
  assign feed_veh = (feed_cnt_r == '0);
  assign cnt_m1   = feed_cnt_r - 1'b1;

  assign cmd.load  = accept && (in_item.kind == ntdr_pkg::KIND_LOAD) && slot_hit;
  assign cmd.shift = feed_on && !feed_veh;
  assign cmd.take  = (state_r == ST_SCAN) && sts.done && sts.found;
  assign cell_addr = cmd.take ? best_idx : ld_addr;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    localparam int NB = (i + 1) % TASK_SLOTS;
    ntdr_cell #(
      .PW (PW),
      .IW (IW),
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .addr    (cell_addr),
      .ld_ready(in_item.ready_flag),
      .ld_pos  (in_item.position[PW-1:0]),
      .owner_i (veh_id_r),
      .nb_ready(c_ready[NB]),
      .nb_pos  (c_pos[NB]),
      .ready_o (c_ready[i]),
      .pos_o   (c_pos[i])
    );
  end

  assign p_ctl[0].valid   = feed_on;
  assign p_ctl[0].vehicle = feed_veh;
  assign p_ctl[0].ready   = !feed_veh && c_ready[0];
  assign p_ctl[0].last    = (32'(feed_cnt_r) == TASK_SLOTS);
  assign p_rem[0]         = feed_veh ? veh_pos_r : c_pos[0];
  assign p_raw[0]         = feed_veh ? veh_pos_r : c_pos[0];
  assign p_idx[0]         = cnt_m1[IW-1:0];

  for (genvar s = 0; s < PW; s++) begin : g_rdc
    ntdr_rdc_stage #(
      .PW   (PW),
      .IW   (IW),
      .SHIFT(PW - 1 - s)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .trk_len(trk_len_r),
      .ctl_i  (p_ctl[s]),
      .rem_i  (p_rem[s]),
      .raw_i  (p_raw[s]),
      .idx_i  (p_idx[s]),
      .ctl_o  (p_ctl[s+1]),
      .rem_o  (p_rem[s+1]),
      .raw_o  (p_raw[s+1]),
      .idx_o  (p_idx[s+1])
    );
  end

  ntdr_pick #(
    .PW(PW),
    .IW(IW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (accept),
    .trk_len    (trk_len_r),
    .ctl_i      (p_ctl[PW]),
    .rem_i      (p_rem[PW]),
    .raw_i      (p_raw[PW]),
    .idx_i      (p_idx[PW]),
    .sts_o      (sts),
    .best_idx_o (best_idx),
    .best_dist_o(best_dist),
    .best_raw_o (best_raw)
  );

  assign best_idx32 = 32'(best_idx);
  assign best_raw32 = 32'(best_raw);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    feed_cnt_nxt  = feed_cnt_r;
    veh_pos_nxt   = veh_pos_r;
    veh_id_nxt    = veh_id_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.kind == ntdr_pkg::KIND_DISPATCH && in_item.ready_flag) begin
            state_nxt    = ST_SCAN;
            feed_cnt_nxt = '0;
            veh_pos_nxt  = in_item.position[PW-1:0];
            veh_id_nxt   = in_item.vehicle_id;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (feed_on) begin
          feed_cnt_nxt = feed_cnt_r + 1'b1;
        end
        if (sts.done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (sts.found) begin
            out_item_nxt.found           = 1'b1;
            out_item_nxt.task_slot       = best_idx32[ntdr_pkg::SLOT_W-1:0];
            out_item_nxt.distance        = best_dist;
            out_item_nxt.target_position = best_raw32[ntdr_pkg::POS_W-1:0];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      feed_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      feed_cnt_r  <= feed_cnt_nxt;
    end
    out_item_r <= out_item_nxt;
    veh_pos_r  <= veh_pos_nxt;
    veh_id_r   <= veh_id_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `NTDR_ASSERT_IMP(a_result_when_idle, out_valid, !busy, "result shown while busy")
  `NTDR_ASSERT_IMP(a_not_found_zero, out_valid && !out_item.found, (out_item.task_slot == '0) && (out_item.distance == '0) && (out_item.target_position == '0), "not-found result carries data")
  `NTDR_ASSERT_NXT(a_load_answers, accept && (in_item.kind == ntdr_pkg::KIND_LOAD), out_valid && !out_item.found, "load item gave no plain result")
  `NTDR_ASSERT_NXT(a_dispatch_scans, accept && (in_item.kind == ntdr_pkg::KIND_DISPATCH) && in_item.ready_flag, busy && !out_valid, "idle-vehicle dispatch did not start a scan")

endmodule

// File: verif/nearest_task_dispatch_ring_unit_test.sv
// Self-checking testbench for nearest_task_dispatch_ring_unit: drives load and dispatch items,
// programs the track length over the APB port and checks every result against a predictor.
// Depends on ntdr_pkg and the RTL of the block only.
module nearest_task_dispatch_ring_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ntdr_pkg::*;

  localparam int SLOTS = 64;
  localparam int PHASE_ITEMS = 105;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_PHASE = 3;
  localparam logic [2:0] TRACK_ADDR = 3'(4 * int'(CFG_IDX_TRACK));

  // Holds a copy of the task table and the outstanding results of load and dispatch items.
  class dispatch_ledger;
    logic [LEN_W-1:0] track_len;
    bit               slot_ready [SLOTS];
    logic [POS_W-1:0] slot_pos   [SLOTS];
    logic [VID_W-1:0] slot_owner [SLOTS];
    out_item_t        expected_replies [$];
    int errors, loads, dispatches, assigned, replies;

    function new();
      track_len = TRACK_RESET;
      foreach (slot_ready[i]) begin
        slot_ready[i] = 1'b0;
        slot_pos[i]   = '0;
        slot_owner[i] = '0;
      end
      errors = 0;
      loads = 0;
      dispatches = 0;
      assigned = 0;
      replies = 0;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) begin
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
      end
    endfunction

    function int unsigned wrap(logic [POS_W-1:0] p);
      if (track_len == 0) return 0;
      return int'(p) % int'(track_len);
    endfunction

    function void take_command(in_item_t cmd);
      out_item_t   reply;
      int          best;
      int unsigned best_dist, from, to, d;
      reply = '0;
      best = -1;
      best_dist = 0;
      from = wrap(cmd.position);
      if (cmd.kind == KIND_LOAD) begin
        loads++;
        slot_ready[cmd.slot] = cmd.ready_flag;
        slot_pos[cmd.slot]   = cmd.position;
      end else begin
        dispatches++;
        if (cmd.ready_flag) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_ready[i]) begin
              to = wrap(slot_pos[i]);
              d = (to >= from) ? to - from : int'(track_len) - from + to;
              // Strict compare keeps the lowest slot on a tie.
              if (best < 0 || d < best_dist) begin
                best = i;
                best_dist = d;
              end
            end
          end
        end
        if (best >= 0) begin
          assigned++;
          slot_ready[best] = 1'b0;
          slot_owner[best] = cmd.vehicle_id;
          reply.found = 1'b1;
          reply.task_slot = SLOT_W'(best);
          reply.distance = POS_W'(best_dist);
          reply.target_position = slot_pos[best];
        end
      end
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      replies++;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 10) $display("MISMATCH result %0h with nothing outstanding", got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.task_slot !== want.task_slot) flag("task_slot", want.task_slot, got.task_slot);
      if (got.distance !== want.distance) flag("distance", want.distance, got.distance);
      if (got.target_position !== want.target_position) begin
        flag("target_position", want.target_position, got.target_position);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dispatch_ledger   ledger = new();
  logic [POS_W-1:0] tie_pool [4];
  int               settings = 0;

  nearest_task_dispatch_ring_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result of the previous item may come at the same edge as the next item is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) ledger.check_reply(out_item);
      if (start && !busy) ledger.take_command(in_item);
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) stalled = 0;
      else stalled++;
    end
    $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("nearest_task_dispatch_ring_unit_test: errors");
    $finish;
  end

  task automatic send(in_item_t cmd);
    in_item <= cmd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.expected_replies.size() != 0 || busy);
  endtask

  task automatic cfg_access(logic write, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= TRACK_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_track(logic [LEN_W-1:0] len);
    logic [31:0] back;
    drain();
    cfg_access(1'b1, {{(32-LEN_W){1'b0}}, len}, back);
    ledger.track_len = len;
    // The port goes idle between the write and the readback.
    @(posedge clk);
    cfg_access(1'b0, '0, back);
    if (back[LEN_W-1:0] !== len) ledger.flag("track_length readback", len, back);
    settings++;
  endtask

  function automatic in_item_t mk(logic kind, int slot, int pos, logic flag, int vid);
    in_item_t cmd;
    cmd.kind = kind;
    cmd.slot = SLOT_W'(slot);
    cmd.position = POS_W'(pos);
    cmd.ready_flag = flag;
    cmd.vehicle_id = VID_W'(vid);
    return cmd;
  endfunction

  // Positions cluster on zero, the top of the field, the track end and a small
  // pool of aliasing values, so that wraps and ties come up often.
  function automatic logic [POS_W-1:0] pick_pos();
    int unsigned len;
    len = ledger.track_len;
    case ($urandom_range(0, 6))
      0, 1: return POS_W'($urandom);
      2: return $urandom_range(0, 1) ? '0 : '1;
      3: return (len == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, len - 1));
      4: return POS_W'(len + $urandom_range(0, 2) - 1);
      default: return tie_pool[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t cmd;
    cmd.kind = ($urandom_range(0, 99) < 55) ? KIND_LOAD : KIND_DISPATCH;
    cmd.slot = SLOT_W'($urandom);
    cmd.position = pick_pos();
    cmd.ready_flag = ($urandom_range(0, 9) < 8);
    cmd.vehicle_id = VID_W'($urandom);
    return cmd;
  endfunction

  initial begin
    logic [31:0]      back;
    logic [LEN_W-1:0] lens [7];
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_access(1'b0, '0, back);
    if (back[LEN_W-1:0] !== TRACK_RESET) ledger.flag("track_length after reset", TRACK_RESET, back);

    // Empty table, then a busy vehicle with every other field at its top value.
    send(mk(KIND_DISPATCH, 0, 0, 1'b1, 0));
    send(mk(KIND_DISPATCH, 63, 20'hFFFFF, 1'b0, 255));
    send(mk(KIND_LOAD, 0, 0, 1'b1, 0));
    send(mk(KIND_LOAD, 63, 20'hFFFFF, 1'b1, 0));
    send(mk(KIND_LOAD, 10, 80000, 1'b1, 0));
    send(mk(KIND_LOAD, 5, 79999, 1'b1, 0));
    send(mk(KIND_LOAD, 6, 40000, 1'b0, 0));
    send(mk(KIND_DISPATCH, 0, 0, 1'b0, 7));
    // Slots 0 and 10 both reduce to zero; the lower one must win first.
    send(mk(KIND_DISPATCH, 0, 0, 1'b1, 1));
    send(mk(KIND_DISPATCH, 0, 160000, 1'b1, 2));
    send(mk(KIND_DISPATCH, 0, 79999, 1'b1, 255));
    send(mk(KIND_DISPATCH, 0, 10000, 1'b1, 3));
    send(mk(KIND_DISPATCH, 0, 500, 1'b1, 4));
    send(mk(KIND_LOAD, 6, 40000, 1'b1, 0));
    send(mk(KIND_LOAD, 6, 40000, 1'b0, 0));
    send(mk(KIND_DISPATCH, 0, 40000, 1'b1, 5));
    send(mk(KIND_LOAD, 20, 1, 1'b1, 0));
    send(mk(KIND_LOAD, 21, 79999, 1'b1, 0));
    send(mk(KIND_DISPATCH, 0, 2, 1'b1, 8'h55));
    send(mk(KIND_DISPATCH, 0, 20'hFFFFF, 1'b1, 8'hAA));

    lens[0] = 1;
    lens[1] = '1;
    lens[2] = 0;
    lens[3] = 100;
    lens[4] = LEN_W'($urandom_range(1, 20'hFFFFF));
    lens[5] = TRACK_RESET;
    lens[6] = LEN_W'($urandom_range(2, 5000));

    foreach (lens[p]) begin
      set_track(lens[p]);
      tie_pool[0] = '0;
      tie_pool[1] = lens[p];
      tie_pool[2] = POS_W'($urandom);
      tie_pool[3] = POS_W'(2 * lens[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send(random_item());
        if (p != QUIET_PHASE) begin
          if ($urandom_range(0, 99) < 11) pause($urandom_range(1, 12));
          else if ($urandom_range(0, 59) == 0) drain();
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d dispatches (%0d assigned) over %0d track lengths,",
             ledger.loads, ledger.dispatches, ledger.assigned, settings);
    $display("with %0d results checked and %0d mismatches.", ledger.replies, ledger.errors);
    if (ledger.errors == 0 && ledger.expected_replies.size() == 0) begin
      $display("nearest_task_dispatch_ring_unit_test: clean");
    end else begin
      $display("nearest_task_dispatch_ring_unit_test: errors");
    end
    $finish;
  end
endmodule
